[sv/nps_pkg.sv]
// nps_pkg: shared types, constants and the control store of the next-prime search.
// Used by every module of the block and by the channel interfaces.
package nps_pkg;

  localparam int NPS_DATA_WIDTH = 32;
  localparam int PRIME_W        = 31;
  localparam int PC_W           = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV5,
    OP_SQRT,
    OP_D3,
    OP_DIV,
    OP_DADD2,
    OP_INC,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SMALL,
    C_REJECT,
    C_BUSY,
    C_REM_ZERO,
    C_D_GT_LIM,
    C_OUT_FULL,
    C_FIVE_DIV
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic small_prime;
    logic reject;
    logic busy;
    logic rem_zero;
    logic d_gt_lim;
    logic out_full;
    logic five_div;
  } nps_stat_t;

  // step addresses
  localparam pc_t S_IDLE   = 4'd0;
  localparam pc_t S_SMALL  = 4'd1;
  localparam pc_t S_REJ    = 4'd2;
  localparam pc_t S_DIV5   = 4'd3;
  localparam pc_t S_WAIT5  = 4'd4;
  localparam pc_t S_REM5   = 4'd5;
  localparam pc_t S_SQRT   = 4'd6;
  localparam pc_t S_WAITSQ = 4'd7;
  localparam pc_t S_D3     = 4'd8;
  localparam pc_t S_LIM    = 4'd9;
  localparam pc_t S_DIV    = 4'd10;
  localparam pc_t S_WAITD  = 4'd11;
  localparam pc_t S_REMD   = 4'd12;
  localparam pc_t S_DADD   = 4'd13;
  localparam pc_t S_NEXT   = 4'd14;
  localparam pc_t S_EMIT   = 4'd15;

  // control store; a step that does not jump falls through to the next address,
  // and the last step wraps back to idle
  function automatic uword_t rom_word(input pc_t pc);
    uword_t w;
    case (pc)
      S_IDLE:   w = '{OP_LOAD,  C_NO_INPUT, S_IDLE};
      S_SMALL:  w = '{OP_NOP,   C_SMALL,    S_EMIT};
      S_REJ:    w = '{OP_NOP,   C_REJECT,   S_NEXT};
      S_DIV5:   w = '{OP_DIV5,  C_NEVER,    S_IDLE};
      S_WAIT5:  w = '{OP_NOP,   C_BUSY,     S_WAIT5};
      S_REM5:   w = '{OP_NOP,   C_FIVE_DIV, S_NEXT};
      S_SQRT:   w = '{OP_SQRT,  C_NEVER,    S_IDLE};
      S_WAITSQ: w = '{OP_NOP,   C_BUSY,     S_WAITSQ};
      S_D3:     w = '{OP_D3,    C_NEVER,    S_IDLE};
      S_LIM:    w = '{OP_NOP,   C_D_GT_LIM, S_EMIT};
      S_DIV:    w = '{OP_DIV,   C_NEVER,    S_IDLE};
      S_WAITD:  w = '{OP_NOP,   C_BUSY,     S_WAITD};
      S_REMD:   w = '{OP_NOP,   C_REM_ZERO, S_NEXT};
      S_DADD:   w = '{OP_DADD2, C_ALWAYS,   S_LIM};
      S_NEXT:   w = '{OP_INC,   C_ALWAYS,   S_SMALL};
      S_EMIT:   w = '{OP_EMIT,  C_OUT_FULL, S_EMIT};
      default:  w = '{OP_NOP,   C_ALWAYS,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[sv/nps_if.sv]
// nps_if: valid/ready channel interfaces for start words and prime words.
// Depends on nps_pkg for default widths.
interface nps_in_if #(parameter int DATA_WIDTH = nps_pkg::NPS_DATA_WIDTH);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  logic                        valid;
  logic                        ready;
  logic [nps_pkg::PRIME_W-1:0] prime_value;

  modport source (output valid, output prime_value, input ready);
  modport sink   (input valid, input prime_value, output ready);
endinterface

[sv/next_prime_search_top.sv]
// next_prime_search_top: smallest prime >= a signed start word, by trial division.
// Per candidate: a trivial rejection test; otherwise the mod-5 test, the integer square root,
// one trial per odd divisor until one divides or one exceeds the root, then a step on or accept.
// A load step comes before and an emit step after. One word at a time: a new start word is
// taken once the result sits in the output register. Reset (rst_n, synchronous) returns
// the step counter to idle and empties the output register; no clearing pass.
module next_prime_search_top #(
  parameter int DATA_WIDTH = nps_pkg::NPS_DATA_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  nps_in_if.sink   in_ch,
  nps_out_if.source out_ch
);
  import nps_pkg::*;

  localparam int RW = (DATA_WIDTH + 1) / 2;
  localparam int NB = (DATA_WIDTH + 7) / 8;

  op_t                   op;
  nps_stat_t             stat;
  logic [DATA_WIDTH-1:0] cand_r, cand_nxt;
  logic [DATA_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [PRIME_W-1:0]    pv_r, pv_nxt;
  logic                  ov_r, ov_nxt;
  logic [DATA_WIDTH-1:0] load_val;
  logic                  div_start, div_busy;
  logic [DATA_WIDTH-1:0] rem;
  logic                  sq_start, sq_busy;
  logic [RW-1:0]         root;
  logic                  out_full, emit;
  logic [8*NB-1:0]       cand_bytes;
  logic [10:0]           bsum_r, bsum_nxt;
  logic [5:0]            fold;

  nps_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  nps_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (cand_r),
    .divisor   (dvs_r),
    .busy      (div_busy),
    .remainder (rem)
  );

  nps_isqrt #(.DATA_WIDTH(DATA_WIDTH)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (cand_r),
    .busy     (sq_busy),
    .root     (root)
  );

  // negative or small starts collapse to 2
  assign load_val  = (in_ch.start_value[DATA_WIDTH-1] ||
                      $unsigned(in_ch.start_value) <= DATA_WIDTH'(2)) ?
                     DATA_WIDTH'(2) : $unsigned(in_ch.start_value);
  assign div_start = (op == OP_DIV);
  assign sq_start  = (op == OP_SQRT);
  assign out_full  = ov_r && !out_ch.ready;
  assign emit      = (op == OP_EMIT) && !out_full;

  always_comb begin
    // 256 and 16 are both 1 mod 5, so byte and nibble sums keep the residue;
    // odd candidate ending in 5 is the same as divisible by 5
    fold = 6'(bsum_r[3:0]) + 6'(bsum_r[7:4]) + 6'(bsum_r[10:8]);
    stat.in_valid    = in_ch.valid;
    stat.small_prime = (cand_r == DATA_WIDTH'(2)) || (cand_r == DATA_WIDTH'(5));
    stat.reject      = (cand_r <= DATA_WIDTH'(1)) || !cand_r[0];
    stat.busy        = div_busy || sq_busy;
    stat.rem_zero    = (rem == '0);
    stat.d_gt_lim    = dvs_r > DATA_WIDTH'(root);
    stat.out_full    = out_full;
    stat.five_div    = (fold == 6'd0)  || (fold == 6'd5)  || (fold == 6'd10) ||
                       (fold == 6'd15) || (fold == 6'd20) || (fold == 6'd25) ||
                       (fold == 6'd30) || (fold == 6'd35);
  end

  always_comb begin
    cand_nxt   = cand_r;
    dvs_nxt    = dvs_r;
    cand_bytes = (8*NB)'(cand_r);
    bsum_nxt   = bsum_r;
    case (op)
      OP_LOAD:  if (in_ch.valid) cand_nxt = load_val;
      OP_INC:   cand_nxt = cand_r + DATA_WIDTH'(1);
      OP_D3:    dvs_nxt  = DATA_WIDTH'(3);
      OP_DADD2: dvs_nxt  = dvs_r + DATA_WIDTH'(2);
      default: ;
    endcase
    if (op == OP_DIV5) begin
      bsum_nxt = '0;
      for (int i = 0; i < NB; i++) begin
        bsum_nxt = bsum_nxt + 11'(cand_bytes[8*i +: 8]);
      end
    end
    pv_nxt = emit ? PRIME_W'(cand_r) : pv_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    cand_r <= cand_nxt;
    dvs_r  <= dvs_nxt;
    pv_r   <= pv_nxt;
    bsum_r <= bsum_nxt;
  end

  assign in_ch.ready        = (op == OP_LOAD);
  assign out_ch.valid       = ov_r;
  assign out_ch.prime_value = pv_r;

  a_load_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (cand_r >= DATA_WIDTH'(2)))
    else $error("candidate loaded below 2");

  a_emit_odd: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (cand_r[0] || cand_r == DATA_WIDTH'(2)))
    else $error("even candidate other than 2 emitted");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_root_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_D3) |-> (!sq_busy && !div_busy))
    else $error("divisor trials begun before root settled");

  a_emit_ovr: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable(pv_r)))
    else $error("waiting result word overwritten");

endmodule

[sv/nps_divider.sv]
// nps_divider: restoring remainder unit, one quotient bit per cycle.
// Depends on nps_pkg only for the default width; used for the odd divisor trials.
module nps_divider #(
  parameter int DATA_WIDTH = nps_pkg::NPS_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  busy,
  output logic [DATA_WIDTH-1:0] remainder
);
  import nps_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] n_r, n_nxt;
  logic [DATA_WIDTH-1:0] d_r, d_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [DATA_WIDTH:0]   shifted;

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, n_r[DATA_WIDTH-1]};
    if (start) begin
      n_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DATA_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[DATA_WIDTH-2:0], 1'b0};
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = DATA_WIDTH'(shifted - {1'b0, d_r});
      end else begin
        rem_nxt = shifted[DATA_WIDTH-1:0];
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

[sv/nps_isqrt.sv]
// nps_isqrt: digit-by-digit floor square root, one root bit per cycle.
// Depends on nps_pkg; run at most once per candidate to set the divisor limit.
module nps_isqrt #(
  parameter int DATA_WIDTH = nps_pkg::NPS_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DATA_WIDTH-1:0]         radicand,
  output logic                          busy,
  output logic [(DATA_WIDTH+1)/2-1:0]   root
);
  import nps_pkg::*;

  localparam int RW = (DATA_WIDTH + 1) / 2;
  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] n_r, n_nxt;
  logic [RW+1:0]   rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    // partial remainder stays below 2^RW before the final step
    rem_sh   = {rem_r[RW-1:0], n_r[2*RW-1 -: 2]};
    trial    = {root_r, 2'b01};
    if (start) begin
      n_nxt    = (2*RW)'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[2*RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[sv/nps_sequencer.sv]
// nps_sequencer: step counter over the control store, with conditional jumps.
// Depends on nps_pkg for the control word, status struct and program.
module nps_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  nps_pkg::nps_stat_t stat,
  output nps_pkg::op_t       op
);
  import nps_pkg::*;

  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw = rom_word(pc_r);
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !stat.in_valid;
      C_SMALL:    take = stat.small_prime;
      C_REJECT:   take = stat.reject;
      C_BUSY:     take = stat.busy;
      C_REM_ZERO: take = stat.rem_zero;
      C_D_GT_LIM: take = stat.d_gt_lim;
      C_OUT_FULL: take = stat.out_full;
      C_FIVE_DIV: take = stat.five_div;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? uw.target : pc_r + pc_t'(1);
    op     = uw.op;
  end

endmodule
